FILE: rtl/core/ipv4_dotted_text_parser_assert.svh
// Assertion macros for the IPv4 dotted-text parser.
`ifndef IPV4_DOTTED_TEXT_PARSER_ASSERT_SVH
`define IPV4_DOTTED_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IPV4TP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipv4 parser assertion failed");

// Next-cycle implication, checked outside reset.
`define IPV4TP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipv4 parser assertion failed");

`endif

FILE: rtl/core/ipv4tp_pkg.sv
// Shared types, character codes and digit decode for the IPv4 text parser.
package ipv4tp_pkg;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LO_X    = 8'h78;

    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // Digit value 0..15, or DIGIT_NONE for anything that is no digit.
    function automatic logic [4:0] digit_of(input logic [7:0] ch);
        logic [7:0] t;
        t = 8'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            t = ch - CH_ZERO;
        end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
            t = ch - CH_UP_A + 8'd10;
        end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
            t = ch - CH_LO_A + 8'd10;
        end else begin
            t = {3'd0, DIGIT_NONE};
        end
        return t[4:0];
    endfunction

    function automatic logic [4:0] radix_value(input t_radix rx);
        logic [4:0] r;
        case (rx)
            RX_DEC:  r = 5'd10;
            RX_OCT:  r = 5'd8;
            default: r = 5'd16;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/ipv4_dotted_text_parser.sv
// A final character passes the input register; when it advances, its result is registered in the result stage.
// Throughput: one character per cycle unless a final character stalls; the per-character update
// is one shift-add of the part value and its overflow check between the input and state registers.
// Only final characters give a result; one waits in the input register while a result is unread.
// Reset (synchronous, active low) empties both stages and clears the parse state.
// The parse state returns to its reset value after every final character.
`include "ipv4_dotted_text_parser_assert.svh"

module ipv4_dotted_text_parser
    import ipv4tp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] address_word
    output logic        m_tuser    // [0] is_valid
);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_PREFIX = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    // input stage
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // parse state
    t_phase      r_phase, n_phase;
    t_radix      r_radix, n_radix;
    logic [31:0] r_value, n_value;
    logic [1:0]  r_parts, n_parts;
    logic [23:0] r_lead,  n_lead;
    logic        r_err,   n_err;
    logic        r_ended, n_ended;

    // result stage
    logic        r_out_vld;
    logic        r_out_ok,   n_out_ok;
    logic [31:0] r_out_addr, n_out_addr;

    logic        w_advance;
    logic        w_take_last;
    logic        w_idle_state;
    logic [4:0]  w_digit;
    t_radix      w_rad;
    logic [35:0] w_mul;
    logic [35:0] w_sum;
    logic        w_ovf;

    assign w_advance   = r_in_vld && (!r_in_last || !r_out_vld || m_tready);
    assign w_take_last = w_advance && r_in_last;
    assign s_tready    = !r_in_vld || w_advance;

    assign w_idle_state = r_phase == PH_START && r_parts == 2'd0 && !r_err && !r_ended &&
                          r_value == 32'd0;

    // after a lone leading zero any further digit is octal
    assign w_rad   = (r_phase == PH_ZERO) ? RX_OCT : r_radix;
    assign w_digit = digit_of(r_in_byte);

    always_comb begin
        case (w_rad)
            RX_DEC:  w_mul = ({4'd0, r_value} << 3) + ({4'd0, r_value} << 1);
            RX_OCT:  w_mul = {4'd0, r_value} << 3;
            default: w_mul = {4'd0, r_value} << 4;
        endcase
        w_sum = w_mul + {31'd0, w_digit};
        w_ovf = |w_sum[35:32];
    end

    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_value = r_value;
        n_parts = r_parts;
        n_lead  = r_lead;
        n_err   = r_err;
        n_ended = r_ended;

        if (!r_ended && !r_err) begin
            if (r_in_byte == CH_DOT) begin
                if (r_phase == PH_START || r_phase == PH_PREFIX ||
                    |r_value[31:8] || r_parts == 2'd3) begin
                    n_err = 1'b1;
                end else begin
                    n_lead  = {r_lead[15:0], r_value[7:0]};
                    n_parts = r_parts + 2'd1;
                    n_phase = PH_START;
                    n_radix = RX_DEC;
                    n_value = 32'd0;
                end
            end else if (r_in_byte == CH_SLASH || r_in_byte == CH_PERCENT) begin
                n_ended = 1'b1;
            end else if (r_phase == PH_START && r_in_byte == CH_ZERO) begin
                n_phase = PH_ZERO;
                n_value = 32'd0;
            end else if (r_phase == PH_ZERO &&
                         (r_in_byte == CH_LO_X || r_in_byte == CH_UP_X)) begin
                n_radix = RX_HEX;
                n_phase = PH_PREFIX;
            end else begin
                n_radix = w_rad;
                if (w_digit >= radix_value(w_rad) || w_ovf) begin
                    n_err = 1'b1;
                end else begin
                    n_value = w_sum[31:0];
                    n_phase = PH_DIGITS;
                end
            end
        end
    end

    // final evaluation on the state that includes this character
    always_comb begin
        n_out_ok   = !n_err && n_parts != 2'd0 &&
                     n_phase != PH_START && n_phase != PH_PREFIX;
        n_out_addr = 32'd0;
        case (n_parts)
            2'd1: begin
                if (|n_value[31:24]) n_out_ok = 1'b0;
                n_out_addr = {n_lead[7:0], n_value[23:0]};
            end
            2'd2: begin
                if (|n_value[31:16]) n_out_ok = 1'b0;
                n_out_addr = {n_lead[15:0], n_value[15:0]};
            end
            2'd3: begin
                if (|n_value[31:8]) n_out_ok = 1'b0;
                n_out_addr = {n_lead[23:0], n_value[7:0]};
            end
            default: n_out_ok = 1'b0;
        endcase
        if (!n_out_ok) n_out_addr = 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_START;
            r_radix   <= RX_DEC;
            r_value   <= 32'd0;
            r_parts   <= 2'd0;
            r_lead    <= 24'd0;
            r_err     <= 1'b0;
            r_ended   <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_vld <= s_tvalid;
            end
            if (w_take_last) begin
                r_out_vld  <= 1'b1;
                r_out_ok   <= n_out_ok;
                r_out_addr <= n_out_addr;
                r_phase    <= PH_START;
                r_radix    <= RX_DEC;
                r_value    <= 32'd0;
                r_parts    <= 2'd0;
                r_lead     <= 24'd0;
                r_err      <= 1'b0;
                r_ended    <= 1'b0;
            end else begin
                if (m_tready) r_out_vld <= 1'b0;
                if (w_advance) begin
                    r_phase <= n_phase;
                    r_radix <= n_radix;
                    r_value <= n_value;
                    r_parts <= n_parts;
                    r_lead  <= n_lead;
                    r_err   <= n_err;
                    r_ended <= n_ended;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_addr;
    assign m_tuser  = r_out_ok;

    `IPV4TP_ASSERT_NOW(a_invalid_addr_zero, i_clk, i_rst_n, r_out_vld && !r_out_ok, !(|r_out_addr))
    `IPV4TP_ASSERT_NEXT(a_final_clears_state, i_clk, i_rst_n, w_take_last, w_idle_state)
    `IPV4TP_ASSERT_NEXT(a_final_gives_result, i_clk, i_rst_n, w_take_last, r_out_vld)
    `IPV4TP_ASSERT_NOW(a_prefix_is_hex, i_clk, i_rst_n, r_phase == PH_PREFIX, r_radix == RX_HEX)
    `IPV4TP_ASSERT_NOW(a_no_stall_midtext, i_clk, i_rst_n, r_in_vld && !r_in_last, w_advance)

endmodule

FILE: verif/ipv4_dotted_text_parser_test.sv
// Self-checking stream testbench for the IPv4 dotted-text address parser.
`timescale 1ns / 100ps

module ipv4_dotted_text_parser_test
    import ipv4tp_pkg::*;
();

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_BYTES  = 590;
    localparam int TAIL_CYCLES  = 10;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [1:0] {
        PART_START,
        PART_ZERO,
        PART_PREFIX,
        PART_DIGITS
    } t_part_phase;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold;   // wait for all pending results before sending
    } t_text_item;

    typedef struct {
        logic        ok;
        logic [31:0] addr;
    } t_addr_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] text_byte
    logic        s_tlast  = 1'b0;   // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] address_word
    logic        m_tuser;           // [0] is_valid

    t_text_item   pending_chars[$];
    t_addr_result expected_addrs[$];
    logic [7:0]   text_buf[$];

    int send_idle_pct = 27;
    int recv_idle_pct = 76;
    int fail_count    = 0;
    int stall_cycles  = 0;

    // parser shadow state
    t_part_phase phase_q;
    t_radix      radix_q;
    logic [32:0] value_q;
    int unsigned dots_q;
    logic [23:0] lead_q;
    bit          err_q;
    bit          ended_q;

    ipv4_dotted_text_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 i_clk = ~i_clk;

    task automatic clear_part();
        phase_q = PART_START;
        radix_q = RX_DEC;
        value_q = 33'd0;
    endtask

    task automatic clear_parse();
        clear_part();
        dots_q  = 0;
        lead_q  = 24'd0;
        err_q   = 1'b0;
        ended_q = 1'b0;
    endtask

    function automatic int unsigned char_digit(input logic [7:0] ch);
        if (ch >= CH_ZERO && ch <= CH_NINE) return 32'(ch - CH_ZERO);
        if (ch >= CH_UP_A && ch <= CH_UP_F) return 32'(ch - CH_UP_A) + 10;
        if (ch >= CH_LO_A && ch <= CH_LO_F) return 32'(ch - CH_LO_A) + 10;
        return 16;
    endfunction

    task automatic feed_digit(input logic [7:0] ch);
        int unsigned d;
        int unsigned r;
        logic [37:0] nxt;
        d = char_digit(ch);
        case (radix_q)
            RX_DEC:  r = 10;
            RX_OCT:  r = 8;
            default: r = 16;
        endcase
        if (d >= r) begin
            err_q = 1'b1;
        end else begin
            nxt = {5'd0, value_q} * r + d;
            if (nxt > 38'hFFFF_FFFF) begin
                err_q = 1'b1;
                nxt = 38'h1_0000_0000;  // saturate one past 32 bits
            end
            value_q = nxt[32:0];
            phase_q = PART_DIGITS;
        end
    endtask

    task automatic parse_char(input logic [7:0] ch);
        if (ch == CH_DOT) begin
            if (phase_q == PART_START || phase_q == PART_PREFIX ||
                value_q > 33'd255 || dots_q >= 3) begin
                err_q = 1'b1;
            end else begin
                lead_q = {lead_q[15:0], value_q[7:0]};
                dots_q++;
                clear_part();
            end
        end else if (ch == CH_SLASH || ch == CH_PERCENT) begin
            ended_q = 1'b1;
        end else if (phase_q == PART_START) begin
            if (ch == CH_ZERO) begin
                phase_q = PART_ZERO;
                value_q = 33'd0;
            end else begin
                feed_digit(ch);
            end
        end else if (phase_q == PART_ZERO) begin
            if (ch == CH_LO_X || ch == CH_UP_X) begin
                radix_q = RX_HEX;
                phase_q = PART_PREFIX;
            end else begin
                radix_q = RX_OCT;
                feed_digit(ch);
            end
        end else begin
            feed_digit(ch);
        end
    endtask

    // One accepted character; on the final one it yields the address result.
    task automatic parse_step(input logic [7:0] ch, input logic last,
                              output bit got, output t_addr_result res);
        int unsigned rem_bits;
        logic [63:0] lim;
        logic [63:0] word;
        got = 1'b0;
        res.ok = 1'b0;
        res.addr = 32'd0;
        if (!ended_q && !err_q) parse_char(ch);
        if (last) begin
            got = 1'b1;
            res.ok = !err_q && dots_q >= 1 && dots_q <= 3 &&
                     phase_q != PART_START && phase_q != PART_PREFIX;
            if (res.ok) begin
                rem_bits = 8 * (4 - dots_q);
                lim = (64'd1 << rem_bits) - 64'd1;
                if ({31'd0, value_q} > lim) begin
                    res.ok = 1'b0;
                end else begin
                    word = ({40'd0, lead_q} << rem_bits) | {31'd0, value_q};
                    res.addr = word[31:0];
                end
            end
            clear_parse();
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("mismatch: %s", msg);
    endtask

    // ---------------- stimulus building ----------------

    task automatic add_char(input logic [7:0] ch);
        text_buf.push_back(ch);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic queue_text(input bit hold);
        t_text_item it;
        for (int i = 0; i < text_buf.size(); i++) begin
            it.ch   = text_buf[i];
            it.last = (i == text_buf.size() - 1);
            it.hold = hold && (i == 0);
            pending_chars.push_back(it);
        end
    endtask

    task automatic queue_str(input string s, input bit hold);
        text_buf.delete();
        add_str(s);
        queue_text(hold);
    endtask

    function automatic string spell_number(input longint unsigned v);
        string h;
        case ($urandom_range(5))
            3: return $sformatf("0%0o", v);
            4: return $sformatf("0x%0h", v);
            5: begin
                h = $sformatf("%0h", v);
                h = h.toupper();
                return {"0X", h};
            end
            default: return $sformatf("%0d", v);
        endcase
    endfunction

    function automatic longint unsigned leading_value();
        case ($urandom_range(15))
            0: return 0;
            1: return 255;
            2: return 64'($urandom_range(4095, 256));
            default: return 64'($urandom_range(255));
        endcase
    endfunction

    function automatic longint unsigned trailing_value(input int dots);
        int w;
        longint unsigned lim;
        w = (dots == 0) ? 32 : (dots >= 4) ? 8 : 8 * (4 - dots);
        lim = (64'd1 << w) - 1;
        case ($urandom_range(9))
            0: return lim;
            1: return lim + 1;
            2: return 64'h1_0000_0000 + $urandom_range(99);
            3: return 64'($urandom);
            default: return $urandom & ((64'd1 << $urandom_range(w, 1)) - 1);
        endcase
    endfunction

    // Mostly well-formed addresses with random content, some broken on purpose.
    task automatic build_random_text();
        int nparts;
        int idx;
        string digits;
        digits = "0123456789abcdefABCDEFxX";
        text_buf.delete();
        case ($urandom_range(19))
            0: nparts = 1;
            1: nparts = 5;
            default: nparts = $urandom_range(4, 2);
        endcase
        for (int p = 0; p < nparts; p++) begin
            if (p > 0) add_char(CH_DOT);
            if (p < nparts - 1) add_str(spell_number(leading_value()));
            else add_str(spell_number(trailing_value(nparts - 1)));
        end
        if ($urandom_range(4) == 0) begin
            idx = $urandom_range(text_buf.size() - 1);
            case ($urandom_range(5))
                0: text_buf[idx] = 8'($urandom_range(255));
                1: text_buf.insert(idx, 8'($urandom_range(255)));
                2: text_buf.insert(idx, CH_DOT);
                3: add_char(CH_DOT);
                4: begin
                    // bare hex prefix as the first part
                    text_buf.push_front(CH_DOT);
                    text_buf.push_front(CH_LO_X);
                    text_buf.push_front(CH_ZERO);
                end
                default: begin
                    repeat ($urandom_range(12, 1)) add_char(digits[$urandom_range(23)]);
                end
            endcase
        end
        if ($urandom_range(6) == 0) begin
            add_char($urandom_range(1) ? CH_SLASH : CH_PERCENT);
            repeat ($urandom_range(4)) add_char(8'($urandom_range(255)));
        end
    endtask

    task automatic queue_random(input int nbytes);
        int queued;
        queued = 0;
        while (queued < nbytes) begin
            build_random_text();
            queued += text_buf.size();
            queue_text($urandom_range(19) == 0);
        end
    endtask

    task automatic wait_idle();
        while (pending_chars.size() != 0 || s_tvalid || expected_addrs.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        t_text_item   nxt;
        t_addr_result res;
        bit           got;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            clear_parse();
        end else begin
            if (s_tvalid && s_tready) begin
                parse_step(s_tdata, s_tlast, got, res);
                if (got) expected_addrs.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(pending_chars[0].hold && expected_addrs.size() != 0)) begin
                    nxt = pending_chars.pop_front();
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver and monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_addr_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_addrs.size() == 0) begin
                note_failure($sformatf("unexpected result valid=%b addr=%h", m_tuser, m_tdata));
            end else begin
                want = expected_addrs.pop_front();
                if (m_tuser !== want.ok || m_tdata !== want.addr)
                    note_failure($sformatf("valid exp %b got %b, addr exp %h got %h",
                                           want.ok, m_tuser, want.addr, m_tdata));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_str("1.2.3.4", 1'b0);
        queue_str("255.255.255.255", 1'b0);
        queue_str("0.0.0.0", 1'b0);
        queue_str("0x7f.1", 1'b0);
        queue_str("0XAB.0377.0xFfFf", 1'b0);
        queue_str("010.0.1.9", 1'b0);
        queue_str("1.16777215", 1'b0);
        queue_str("1.16777216", 1'b0);     // last part too wide
        queue_str("1.2.65535", 1'b0);
        queue_str("1.2.65536", 1'b0);
        queue_str("1.2.3.256", 1'b0);
        queue_str("256.1", 1'b0);          // leading part above a byte
        queue_str("1..2", 1'b0);           // empty part
        queue_str("1.2.", 1'b0);
        queue_str("0x.1", 1'b0);           // hex prefix without digits
        queue_str("1.0x", 1'b0);
        queue_str("0.08", 1'b0);           // octal with bad digit
        queue_str("1.2.3.4.5", 1'b0);      // one dot too many
        queue_str("1234", 1'b0);           // no dot at all
        queue_str("1.4294967296", 1'b0);   // beyond 32 bits
        queue_str("1.2.3.4/24x", 1'b0);
        queue_str("10.1%eth0", 1'b0);
        queue_str("1.2.3.4g", 1'b1);
        text_buf.delete();
        add_str("1.2.");
        add_char(8'hFF);
        queue_text(1'b0);
        text_buf.delete();
        add_char(CH_SLASH);
        add_char(8'h00);
        queue_text(1'b0);

        queue_random(PHASE_BYTES);
        wait_idle();

        send_idle_pct = 76;
        recv_idle_pct = 27;
        queue_random(PHASE_BYTES);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(PHASE_BYTES);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_addrs.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_addrs.size()));
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ipv4tp_pkg.sv
rtl/core/ipv4_dotted_text_parser.sv
verif/ipv4_dotted_text_parser_test.sv
